### design/mhtq_pkg.sv
// Shared types, result codes and datapath command codes for the timer queue.
`default_nettype none
package mhtq_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [2:0] K_ADDED     = 3'd0;
    localparam logic [2:0] K_FULL      = 3'd1;
    localparam logic [2:0] K_CANCELLED = 3'd2;
    localparam logic [2:0] K_IGNORED   = 3'd3;
    localparam logic [2:0] K_FIRED     = 3'd4;
    localparam logic [2:0] K_DONE      = 3'd5;

    localparam logic [1:0] M_ADD    = 2'd0;
    localparam logic [1:0] M_CANCEL = 2'd1;
    localparam logic [1:0] M_CHECK  = 2'd2;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_ADD_INIT = 4'd1;
    localparam logic [3:0] OP_UP_STEP  = 4'd2;
    localparam logic [3:0] OP_CAN_INIT = 4'd3;
    localparam logic [3:0] OP_CAN_MOVE = 4'd4;
    localparam logic [3:0] OP_DN_A     = 4'd5;
    localparam logic [3:0] OP_DN_B     = 4'd6;
    localparam logic [3:0] OP_CHK_TOP  = 4'd7;
    localparam logic [3:0] OP_CHK_MOVE = 4'd8;
    localparam logic [3:0] OP_EMIT     = 4'd9;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] now;
        logic [31:0] delay;
        logic [3:0]  timer_id;
        logic [15:0] handler;
        logic [31:0] tag;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot_id;
        logic [15:0] fired_handler;
        logic [31:0] fired_tag;
        logic        next_valid;
        logic [31:0] next_delay;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       ignore;
        logic       skip;
        logic       go_down;
        logic       settled;
        logic       fire;
        logic       count_zero;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

### design/min_heap_timer_queue_unit.sv
// Top level of the min-heap timer queue: sequencer, datapath and checks.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_in_data  (mhtq_pkg::t_in)
//  output    out        o_out_valid / i_out_ready o_out_data (mhtq_pkg::t_out)
//
// One transaction in at a time; o_in_ready is high only while idle.
// Add: dispatch and insert, then sift up (UP) a level at a time, then load.
// Cancel: dispatch and unlink, then move the last entry into the hole and sift
// it up or down (DA, DB per level; none when ignored or when the last entry is
// cancelled), then load. Check: dispatch, then per fired timer read the top,
// move the last entry up and sink it (none once the heap is empty), then done.
// Cost is set by the single read port on the heap order and expiry arrays.
// Reset (synchronous, active low) empties the heap and rebuilds the free
// list at once. A stalled output holds the sequencer before the next result.
`default_nettype none
module min_heap_timer_queue_unit #(
    parameter int SLOTS = mhtq_pkg::SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mhtq_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mhtq_pkg::t_out      o_out_data
);
    mhtq_pkg::t_cmd w_cmd;
    mhtq_pkg::t_sts w_sts;

    mhtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mhtq_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a new transaction is never taken right after one is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while busy");

    // only fired results are non-final
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind != mhtq_pkg::K_FIRED) |-> o_out_data.last)
        else $error("final flag missing");

    // a fired result always precedes more output from the same check
    a_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == mhtq_pkg::K_FIRED) |-> !o_in_ready)
        else $error("check ended after a fired result");
endmodule
`default_nettype wire

### design/mhtq_ctrl.sv
// Sequencer for the timer queue: walks add, cancel and check through datapath ops.
`default_nettype none
module mhtq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire mhtq_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output mhtq_pkg::t_cmd     o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_ADD  = 4'd2;
    localparam logic [3:0] S_CAN  = 4'd3;
    localparam logic [3:0] S_CMOV = 4'd4;
    localparam logic [3:0] S_UP   = 4'd5;
    localparam logic [3:0] S_DA   = 4'd6;
    localparam logic [3:0] S_DB   = 4'd7;
    localparam logic [3:0] S_CTOP = 4'd8;
    localparam logic [3:0] S_CMV  = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_ret, n_ret;   // 1: sift returns to check loop
    logic [3:0] w_after;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_after    = r_ret ? S_CTOP : S_EMIT;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd.load = 1'b0;
        o_cmd.op   = mhtq_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                n_ret = (i_sts.mode == mhtq_pkg::M_CHECK);
                if (i_sts.mode == mhtq_pkg::M_ADD) n_state = S_ADD;
                else if (i_sts.mode == mhtq_pkg::M_CANCEL) n_state = S_CAN;
                else if (i_sts.mode == mhtq_pkg::M_CHECK) n_state = S_CTOP;
                else n_state = S_IDLE;
            end
            S_ADD: begin
                o_cmd.op = mhtq_pkg::OP_ADD_INIT;
                n_state  = i_sts.full ? S_EMIT : S_UP;
            end
            S_CAN: begin
                o_cmd.op = mhtq_pkg::OP_CAN_INIT;
                n_state  = i_sts.ignore ? S_EMIT : S_CMOV;
            end
            S_CMOV: begin
                o_cmd.op = mhtq_pkg::OP_CAN_MOVE;
                if (i_sts.skip) n_state = S_EMIT;
                else if (i_sts.go_down) n_state = S_DA;
                else n_state = S_UP;
            end
            S_UP: begin
                o_cmd.op = mhtq_pkg::OP_UP_STEP;
                if (i_sts.settled) n_state = w_after;
            end
            S_DA: begin
                o_cmd.op = mhtq_pkg::OP_DN_A;
                n_state  = i_sts.settled ? w_after : S_DB;
            end
            S_DB: begin
                o_cmd.op = mhtq_pkg::OP_DN_B;
                n_state  = i_sts.settled ? w_after : S_DA;
            end
            S_CTOP: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mhtq_pkg::OP_CHK_TOP;
                    n_state  = i_sts.fire ? S_CMV : S_IDLE;
                end
            end
            S_CMV: begin
                o_cmd.op = mhtq_pkg::OP_CHK_MOVE;
                n_state  = i_sts.count_zero ? S_CTOP : S_DA;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mhtq_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end
endmodule
`default_nettype wire

### design/mhtq_dp.sv
// Datapath: slot tables, heap arrays, free list, sift unit and output register.
`default_nettype none
module mhtq_dp #(
    parameter int SLOTS = mhtq_pkg::SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mhtq_pkg::t_cmd i_cmd,
    input  wire mhtq_pkg::t_in  i_in_data,
    input  wire logic           i_out_ready,
    output mhtq_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output mhtq_pkg::t_out      o_out_data
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = CW + 1;

    logic [IW-1:0] r_ord  [SLOTS];
    logic [63:0]   r_exp  [SLOTS];
    logic [IW-1:0] r_posn [SLOTS];
    logic [CW-1:0] r_link [SLOTS];
    logic [15:0]   r_hnd  [SLOTS];
    logic [31:0]   r_tag  [SLOTS];
    logic [SLOTS-1:0] r_act;
    logic [CW-1:0] r_free, r_cnt;

    mhtq_pkg::t_in  r_in;
    mhtq_pkg::t_out r_out;
    logic           r_out_valid;
    logic [IW-1:0]  r_pos, r_cur, r_bslot;
    logic [63:0]    r_cur_exp, r_tid_exp, r_bexp;
    logic [XW-1:0]  r_bidx;
    logic [2:0]     r_res_kind;
    logic [3:0]     r_res_slot;

    logic          w_tid_ok, w_full, w_ignore, w_fire, w_up_set, w_dna_end, w_dnb_set;
    logic          w_use2, w_out_load;
    logic [IW-1:0] w_tid, w_s, w_par, w_ord_addr, w_ord_rd, w_exp_addr, w_ch_slot;
    logic [63:0]   w_exp_rd, w_ch_exp, w_diff;
    logic [XW-1:0] w_c1, w_c2, w_ch_idx;
    logic [31:0]   w_nd;

    assign w_tid    = IW'(r_in.timer_id);
    assign w_tid_ok = (32'(r_in.timer_id) < SLOTS);
    assign w_s      = r_free[IW-1:0];
    assign w_full   = (r_free == CW'(SLOTS));
    assign w_par    = IW'((XW'(r_pos) - XW'(1)) >> 1);
    assign w_c1     = XW'({r_pos, 1'b1});
    assign w_c2     = r_bidx + XW'(1);

    always_comb begin
        unique case (i_cmd.op)
            mhtq_pkg::OP_UP_STEP:  w_ord_addr = w_par;
            mhtq_pkg::OP_DN_A:     w_ord_addr = w_c1[IW-1:0];
            mhtq_pkg::OP_DN_B:     w_ord_addr = w_c2[IW-1:0];
            mhtq_pkg::OP_CAN_MOVE,
            mhtq_pkg::OP_CHK_MOVE: w_ord_addr = r_cnt[IW-1:0];
            default:               w_ord_addr = '0;
        endcase
    end

    assign w_ord_rd   = r_ord[w_ord_addr];
    assign w_exp_addr = (i_cmd.op == mhtq_pkg::OP_CAN_INIT) ? w_tid : w_ord_rd;
    assign w_exp_rd   = r_exp[w_exp_addr];

    assign w_up_set  = (r_pos == '0) || !(w_exp_rd > r_cur_exp);
    assign w_dna_end = (w_c1 >= XW'(r_cnt));
    assign w_use2    = (w_c2 < XW'(r_cnt)) && (r_bexp > w_exp_rd);
    assign w_ch_slot = w_use2 ? w_ord_rd : r_bslot;
    assign w_ch_exp  = w_use2 ? w_exp_rd : r_bexp;
    assign w_ch_idx  = w_use2 ? w_c2 : r_bidx;
    assign w_dnb_set = !(r_cur_exp > w_ch_exp);

    assign w_ignore = !w_tid_ok || !r_act[w_tid] || (r_cnt == '0);
    assign w_fire   = (r_cnt != '0) && !(w_exp_rd > r_in.now);
    assign w_diff   = w_exp_rd - r_in.now;
    assign w_nd     = (|w_diff[63:32]) ? '1 : w_diff[31:0];

    assign w_out_load = (i_cmd.op == mhtq_pkg::OP_CHK_TOP) || (i_cmd.op == mhtq_pkg::OP_EMIT);

    always_comb begin
        o_sts.mode       = r_in.mode;
        o_sts.full       = w_full;
        o_sts.ignore     = w_ignore;
        o_sts.skip       = (XW'(r_pos) >= XW'(r_cnt));
        o_sts.go_down    = (w_exp_rd > r_tid_exp);
        o_sts.fire       = w_fire;
        o_sts.count_zero = (r_cnt == '0);
        o_sts.out_free   = !r_out_valid || i_out_ready;
        unique case (i_cmd.op)
            mhtq_pkg::OP_UP_STEP: o_sts.settled = w_up_set;
            mhtq_pkg::OP_DN_A:    o_sts.settled = w_dna_end;
            default:              o_sts.settled = w_dnb_set;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // control state: free list, active flags, count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= '0;
            r_cnt       <= '0;
            r_act       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) r_link[i] <= CW'(i + 1);
        end else begin
            r_out_valid <= w_out_load || (r_out_valid && !i_out_ready);
            unique case (i_cmd.op)
                mhtq_pkg::OP_ADD_INIT: begin
                    if (!w_full) begin
                        r_free     <= r_link[w_s];
                        r_act[w_s] <= 1'b1;
                        r_cnt      <= r_cnt + CW'(1);
                    end
                end
                mhtq_pkg::OP_CAN_INIT: begin
                    if (!w_ignore) begin
                        r_cnt         <= r_cnt - CW'(1);
                        r_link[w_tid] <= r_free;
                        r_act[w_tid]  <= 1'b0;
                        r_free        <= CW'(w_tid);
                    end
                end
                mhtq_pkg::OP_CHK_TOP: begin
                    if (w_fire) begin
                        r_cnt            <= r_cnt - CW'(1);
                        r_link[w_ord_rd] <= r_free;
                        r_act[w_ord_rd]  <= 1'b0;
                        r_free           <= CW'(w_ord_rd);
                    end
                end
                default: ;
            endcase
        end
    end

    // payload: tables, sift registers, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_data;
        unique case (i_cmd.op)
            mhtq_pkg::OP_ADD_INIT: begin
                if (w_full) begin
                    r_res_kind <= mhtq_pkg::K_FULL;
                    r_res_slot <= '0;
                end else begin
                    r_exp[w_s] <= r_in.now + 64'(r_in.delay);
                    r_hnd[w_s] <= r_in.handler;
                    r_tag[w_s] <= r_in.tag;
                    r_pos      <= r_cnt[IW-1:0];
                    r_cur      <= w_s;
                    r_cur_exp  <= r_in.now + 64'(r_in.delay);
                    r_res_kind <= mhtq_pkg::K_ADDED;
                    r_res_slot <= 4'(w_s);
                end
            end
            mhtq_pkg::OP_UP_STEP: begin
                if (w_up_set) begin
                    r_ord[r_pos]  <= r_cur;
                    r_posn[r_cur] <= r_pos;
                end else begin
                    r_ord[r_pos]     <= w_ord_rd;
                    r_posn[w_ord_rd] <= r_pos;
                    r_pos            <= w_par;
                end
            end
            mhtq_pkg::OP_CAN_INIT: begin
                r_res_kind <= w_ignore ? mhtq_pkg::K_IGNORED : mhtq_pkg::K_CANCELLED;
                r_res_slot <= r_in.timer_id;
                r_pos      <= r_posn[w_tid];
                r_tid_exp  <= w_exp_rd;
            end
            mhtq_pkg::OP_CAN_MOVE,
            mhtq_pkg::OP_CHK_MOVE: begin
                r_cur     <= w_ord_rd;
                r_cur_exp <= w_exp_rd;
            end
            mhtq_pkg::OP_DN_A: begin
                if (w_dna_end) begin
                    r_ord[r_pos]  <= r_cur;
                    r_posn[r_cur] <= r_pos;
                end else begin
                    r_bidx  <= w_c1;
                    r_bslot <= w_ord_rd;
                    r_bexp  <= w_exp_rd;
                end
            end
            mhtq_pkg::OP_DN_B: begin
                if (w_dnb_set) begin
                    r_ord[r_pos]  <= r_cur;
                    r_posn[r_cur] <= r_pos;
                end else begin
                    r_ord[r_pos]      <= w_ch_slot;
                    r_posn[w_ch_slot] <= r_pos;
                    r_pos             <= w_ch_idx[IW-1:0];
                end
            end
            mhtq_pkg::OP_CHK_TOP: begin
                r_pos <= '0;
                if (w_fire) begin
                    r_out <= '{kind: mhtq_pkg::K_FIRED, slot_id: 4'(w_ord_rd),
                               fired_handler: r_hnd[w_ord_rd],
                               fired_tag: r_tag[w_ord_rd],
                               next_valid: 1'b0, next_delay: '0, last: 1'b0};
                end else begin
                    r_out <= '{kind: mhtq_pkg::K_DONE, slot_id: '0,
                               fired_handler: '0, fired_tag: '0,
                               next_valid: (r_cnt != '0),
                               next_delay: (r_cnt != '0) ? w_nd : '0, last: 1'b1};
                end
            end
            mhtq_pkg::OP_EMIT: begin
                r_out <= '{kind: r_res_kind, slot_id: r_res_slot,
                           fired_handler: '0, fired_tag: '0,
                           next_valid: 1'b0, next_delay: '0, last: 1'b1};
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
